// ===== hw/rtl/gpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpm_pkg;

    // Fixed field widths of the item and configuration ports
    localparam int CMD_W      = 2;
    localparam int ST_IDX_W   = 6;
    localparam int SLOT_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int CNT_IN_W   = 4;
    localparam int LAST_W     = 6;

    localparam int DEF_MAX_STATES = 64;
    localparam int DEF_NUM_RANGES = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_RANGE = 2'd0,
        CMD_WR_FLAGS = 2'd1,
        CMD_BYTE     = 2'd2,
        CMD_END      = 2'd3
    } cmd_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic                step;
        logic                restart;
        logic                wr_range;
        logic                wr_flags;
        logic [SLOT_W-1:0]   slot;
        logic [BYTE_W-1:0]   lo;
        logic [BYTE_W-1:0]   hi;
        logic [CNT_IN_W-1:0] cnt;
        logic                neg;
        logic                loop;
        logic [BYTE_W-1:0]   subject;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpm_cell #(
    parameter int NUM_RANGES = 8,
    parameter bit HEAD       = 1'b0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire gpm_pkg::ctl_t ctl,
    input  wire logic         sel,
    input  wire logic         carry_in,
    output logic              carry_out,
    output logic              active
);
    import gpm_pkg::*;

    localparam int CNT_W = $clog2(NUM_RANGES + 1);
    localparam int EXT_W = 5;

    logic [BYTE_W-1:0] lows_reg  [NUM_RANGES];
    logic [BYTE_W-1:0] highs_reg [NUM_RANGES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              neg_reg;
    logic              loop_reg;
    logic              active_reg;
    logic              active_next;
    logic              in_range;
    logic              hit;
    logic [EXT_W-1:0]  cnt_ext;
    logic [EXT_W-1:0]  cnt_clamped;

    // Range slot storage, one register pair per slot
    for (genvar k = 0; k < NUM_RANGES; k++) begin : g_slot
        always_ff @(posedge clk)
        begin
            if (ctl.wr_range && sel && ({2'b00, ctl.slot} == EXT_W'(k)))
            begin
                lows_reg[k]  <= ctl.lo;
                highs_reg[k] <= ctl.hi;
            end
        end
    end

    always_comb
    begin
        cnt_ext     = {1'b0, ctl.cnt};
        cnt_clamped = (cnt_ext > EXT_W'(NUM_RANGES)) ? EXT_W'(NUM_RANGES) : cnt_ext;
        count_next  = CNT_W'(cnt_clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            neg_reg   <= 1'b0;
            loop_reg  <= 1'b0;
        end
        else if (ctl.wr_flags && sel)
        begin
            count_reg <= count_next;
            neg_reg   <= ctl.neg;
            loop_reg  <= ctl.loop;
        end
    end

    // Class test against all valid slots at once
    always_comb
    begin
        in_range = 1'b0;
        for (int k = 0; k < NUM_RANGES; k++)
        begin
            if ((CNT_W'(k) < count_reg) && (lows_reg[k] <= ctl.subject)
                && (ctl.subject <= highs_reg[k]))
            begin
                in_range = 1'b1;
            end
        end
        hit = (ctl.subject != '0) && (count_reg != '0) && (neg_reg ? !in_range : in_range);
    end

    always_comb
    begin
        active_next = active_reg;
        if (ctl.restart)
        begin
            active_next = HEAD;
        end
        else if (ctl.step)
        begin
            active_next = (active_reg && loop_reg && (ctl.subject != '0)) || carry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= HEAD;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign carry_out = active_reg && hit;
    assign active    = active_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gpm_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpm_out_buf (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic push_data,
    output logic      full,
    output logic      result_valid,
    input  wire logic result_stall,
    output logic      matched
);
    import gpm_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic out_data_reg;
    logic out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic skid_data_reg;
    logic skid_data_next;
    logic pop;

    assign pop = out_valid_reg && !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign matched      = out_data_reg;

    // skid slot only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into full buffer");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && (out_data_reg == $past(skid_data_reg))))
        else $error("skid entry lost on drain");

endmodule

`default_nettype wire

// ===== hw/rtl/glob_pattern_nfa_matcher_top.sv =====
// Glob matcher, one cell per pattern state in a chain.
// Item channel: item_valid / item_stall with fields command, state_index, slot_index,
// range_low, range_high, range_count, class_negate, self_loop, subject_byte.
// Commands 0 and 1 load a state's range slot or flags; command 2 advances the NFA by
// one subject byte; command 3 ends the subject and yields one result.
// Result channel: result_valid / result_stall carrying matched.
// Throughput: one item per cycle, every command, while item_stall is low; each cell
// compares its own ranges in parallel, so pattern length does not slow a byte.
// matched is taken at the end-of-subject transfer and registered in the output buffer.
// User must write last_state by cfg_wr_en / cfg_wr_data only while idle; unenforced.
// A two-entry output buffer holds results; item_stall rises only when both entries
// are held by a stalled receiver, and stays until one of them transfers.
// Reset (rst_n, async): only state 0 active, all flags and counts zero, last_state
// zero, no result pending. Range slots are not cleared and must be loaded before
// a state's count covers them.
`timescale 1ns / 1ps
`default_nettype none

module glob_pattern_nfa_matcher_top #(
    parameter int MAX_STATES = gpm_pkg::DEF_MAX_STATES,
    parameter int NUM_RANGES = gpm_pkg::DEF_NUM_RANGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gpm_pkg::LAST_W-1:0]      cfg_wr_data,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [gpm_pkg::CMD_W-1:0]       command,
    input  wire logic [gpm_pkg::ST_IDX_W-1:0]    state_index,
    input  wire logic [gpm_pkg::SLOT_W-1:0]      slot_index,
    input  wire logic [gpm_pkg::BYTE_W-1:0]      range_low,
    input  wire logic [gpm_pkg::BYTE_W-1:0]      range_high,
    input  wire logic [gpm_pkg::CNT_IN_W-1:0]    range_count,
    input  wire logic                            class_negate,
    input  wire logic                            self_loop,
    input  wire logic [gpm_pkg::BYTE_W-1:0]      subject_byte,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic                                 matched
);
    import gpm_pkg::*;

    localparam int ST_BITS  = $clog2(MAX_STATES);
    localparam int SEL_W    = (ST_BITS > ST_IDX_W) ? ST_BITS : ST_IDX_W;
    localparam int LS_SPAN  = 1 << LAST_W;

    logic [LAST_W-1:0]     last_state_reg;
    logic                  accept;
    logic                  buf_full;
    logic                  push;
    ctl_t                  ctl;
    logic [MAX_STATES-1:0] act;
    logic [MAX_STATES-1:0] chain;
    logic [LS_SPAN-1:0]    act_ls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            last_state_reg <= cfg_wr_data;
        end
    end

    assign item_stall = buf_full;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        ctl          = '0;
        ctl.slot     = slot_index;
        ctl.lo       = range_low;
        ctl.hi       = range_high;
        ctl.cnt      = range_count;
        ctl.neg      = class_negate;
        ctl.loop     = self_loop;
        ctl.subject  = subject_byte;
        if (accept)
        begin
            case (cmd_t'(command))
                CMD_WR_RANGE: ctl.wr_range = ({2'b00, slot_index} < 5'(NUM_RANGES));
                CMD_WR_FLAGS: ctl.wr_flags = 1'b1;
                CMD_BYTE:     ctl.step     = 1'b1;
                CMD_END:      ctl.restart  = 1'b1;
                default:      ctl.step     = 1'b0;
            endcase
        end
    end

    for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
        logic cin;
        if (i == 0) begin : g_head
            assign cin = 1'b0;
        end
        else begin : g_body
            assign cin = chain[i-1];
        end

        gpm_cell #(
            .NUM_RANGES (NUM_RANGES),
            .HEAD       (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sel       (SEL_W'(state_index) == SEL_W'(i)),
            .carry_in  (cin),
            .carry_out (chain[i]),
            .active    (act[i])
        );
    end

    // States beyond the array never match
    for (genvar j = 0; j < LS_SPAN; j++) begin : g_ls
        if (j < MAX_STATES) begin : g_in
            assign act_ls[j] = act[j];
        end
        else begin : g_out
            assign act_ls[j] = 1'b0;
        end
    end

    assign push = ctl.restart;

    gpm_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (act_ls[last_state_reg]),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched)
    );

    a_restart_head_only: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.restart |=> (act == MAX_STATES'(1)))
        else $error("restart did not leave only the head state active");

    a_zero_byte_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && (subject_byte == '0)) |=> (act == '0))
        else $error("zero byte left a state active");

    a_table_write_keeps_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((command == CMD_WR_RANGE) || (command == CMD_WR_FLAGS))) |=> $stable(act))
        else $error("table write disturbed the active set");

endmodule

`default_nettype wire
